[rtl/bpb_pkg.sv]
package bpb_pkg;

    localparam int PATTERN_SLOTS     = 16;
    localparam int MAX_PATTERN_BYTES = 16;
    localparam int WINDOW_BYTES      = 16;

    localparam int LEN_W    = 5;
    localparam int INDEX_W  = 4;
    localparam int WORD_W   = 64;
    localparam int WEIGHT_W = 16;

    // max tree over the lanes, at least one level
    localparam int MERGE_LEVELS = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
    localparam int MERGE_NODES  = 1 << MERGE_LEVELS;
    localparam int CNT_W        = $clog2(MERGE_LEVELS + 1);

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_MATCH,
        ST_MERGE
    } state_t;

    typedef struct packed
    {
        cmd_t                command;
        logic [INDEX_W-1:0]  entry_index;
        logic [LEN_W-1:0]    pattern_len;
        logic [WORD_W-1:0]   pattern_low;
        logic [WORD_W-1:0]   pattern_high;
        logic [WEIGHT_W-1:0] weight;
        logic [LEN_W-1:0]    old_len;
        logic [WORD_W-1:0]   old_low;
        logic [WORD_W-1:0]   old_high;
        logic [LEN_W-1:0]    new_len;
        logic [WORD_W-1:0]   new_low;
        logic [WORD_W-1:0]   new_high;
    } request_t;

    typedef struct packed
    {
        logic [WEIGHT_W-1:0] boost;
        logic                any_broken;
    } result_t;

    // lane control from the sequencer
    typedef struct packed
    {
        logic write;
        logic match;
    } lane_ctrl_t;

    // what one lane found; weight is zero unless broken
    typedef struct packed
    {
        logic                broken;
        logic [WEIGHT_W-1:0] weight;
    } lane_res_t;

endpackage

[rtl/broken_pattern_boost.sv]
// Pattern-break scorer. A load request (command 0) writes one slot of a
// 16-entry pattern table: up to 16 bytes, a length (0 empties the slot,
// lengths above 16 are held as 16) and an unsigned Q8.8 weight; it answers
// boost 0 and any_broken 0. An evaluate request (command 1) carries an old
// and a new window of up to 16 bytes; a pattern is broken when it occurs in
// the old window and not in the new one, and the result is the largest weight
// of a broken pattern with any_broken set when at least one was found. Every
// request gives exactly one result, in order. The block handles one request
// at a time: it captures the request, then every table slot's lane searches
// both windows at all offsets at once and registers its flag, then the lane
// results climb a registered max tree one level per clock (log2 of the slot
// count, 4 levels at 16 slots), and the answer moves into the result register
// once that register is empty or being emptied. No new request is taken until
// the answer has left the tree, and the tree depth is what sets how long a
// request takes. The result register lets the next request enter while a
// result still waits on result_stall.
module broken_pattern_boost
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              request_valid,
    output logic              request_stall,
    input  bpb_pkg::request_t request,
    output logic              result_valid,
    input  logic              result_stall,
    output bpb_pkg::result_t  result
);

    bpb_pkg::state_t             state_reg;
    bpb_pkg::state_t             state_next;
    logic [bpb_pkg::CNT_W-1:0]   cnt_reg;
    logic [bpb_pkg::CNT_W-1:0]   cnt_next;
    bpb_pkg::request_t           req_reg;
    logic                        result_valid_reg;
    logic                        result_valid_next;
    bpb_pkg::result_t            result_reg;

    logic                        accept;
    logic                        done;
    bpb_pkg::lane_ctrl_t         lane_ctrl [bpb_pkg::PATTERN_SLOTS];
    bpb_pkg::lane_res_t          lane_res  [bpb_pkg::PATTERN_SLOTS];
    bpb_pkg::lane_res_t          tree_top;

    // only idle takes a new request
    assign request_stall = (state_reg != bpb_pkg::ST_IDLE);
    assign accept        = request_valid && !request_stall;

    // tree top is settled once the count reaches the depth; move it out
    // when the result register is empty or being emptied
    assign done = (state_reg == bpb_pkg::ST_MERGE)
               && (cnt_reg == bpb_pkg::CNT_W'(bpb_pkg::MERGE_LEVELS))
               && (!result_valid_reg || !result_stall);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            bpb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = bpb_pkg::ST_MATCH;
                end
            end
            bpb_pkg::ST_MATCH:
            begin
                // lanes register their flags and loads write the table
                state_next = bpb_pkg::ST_MERGE;
                cnt_next   = '0;
            end
            bpb_pkg::ST_MERGE:
            begin
                if (done)
                begin
                    state_next = bpb_pkg::ST_IDLE;
                end
                else if (cnt_reg != bpb_pkg::CNT_W'(bpb_pkg::MERGE_LEVELS))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = bpb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        if (done)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bpb_pkg::ST_IDLE;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // request and result payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if (done)
        begin
            result_reg.boost      <= tree_top.weight;
            result_reg.any_broken <= tree_top.broken;
        end
    end

    // slot decode: a load writes only the addressed lane
    always_comb
    begin
        for (int i = 0; i < bpb_pkg::PATTERN_SLOTS; i++)
        begin
            lane_ctrl[i].match = (state_reg == bpb_pkg::ST_MATCH);
            lane_ctrl[i].write = (state_reg == bpb_pkg::ST_MATCH)
                              && (req_reg.command == bpb_pkg::CMD_LOAD)
                              && (int'(req_reg.entry_index) == i);
        end
    end

    // one lane per table slot
    for (genvar g = 0; g < bpb_pkg::PATTERN_SLOTS; g++)
    begin : g_lane
        bpb_lane u_lane
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lane_ctrl[g]),
            .req   (req_reg),
            .res   (lane_res[g])
        );
    end

    bpb_merge u_merge
    (
        .clk   (clk),
        .lanes (lane_res),
        .top   (tree_top)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[rtl/bpb_lane.sv]
module bpb_lane
(
    input  logic                clk,
    input  logic                rst_n,
    input  bpb_pkg::lane_ctrl_t ctrl,
    input  bpb_pkg::request_t   req,
    output bpb_pkg::lane_res_t  res
);

    logic [bpb_pkg::WORD_W-1:0]   pat_low_reg;
    logic [bpb_pkg::WORD_W-1:0]   pat_high_reg;
    logic [bpb_pkg::LEN_W-1:0]    len_reg;
    logic [bpb_pkg::WEIGHT_W-1:0] weight_reg;
    bpb_pkg::lane_res_t           res_reg;
    bpb_pkg::lane_res_t           res_next;

    logic [bpb_pkg::MAX_PATTERN_BYTES-1:0][7:0] pat_bytes;
    logic [bpb_pkg::WINDOW_BYTES-1:0][7:0]      orig_win;
    logic [bpb_pkg::WINDOW_BYTES-1:0][7:0]      repl_win;
    logic [bpb_pkg::LEN_W-1:0]                  old_len_c;
    logic [bpb_pkg::LEN_W-1:0]                  new_len_c;
    logic                                       old_hit;
    logic                                       new_hit;

    function automatic logic [bpb_pkg::LEN_W-1:0] clamp_len(
        input logic [bpb_pkg::LEN_W-1:0] v,
        input int                        limit
    );
        logic [bpb_pkg::LEN_W-1:0] lim;
        lim = bpb_pkg::LEN_W'(limit);
        return (v > lim) ? lim : v;
    endfunction

    // substring search: every offset in parallel, bytes past the pattern ignored
    function automatic logic holds(
        input logic [bpb_pkg::WINDOW_BYTES-1:0][7:0]      win,
        input logic [bpb_pkg::LEN_W-1:0]                  wlen,
        input logic [bpb_pkg::MAX_PATTERN_BYTES-1:0][7:0] pat,
        input logic [bpb_pkg::LEN_W-1:0]                  plen
    );
        logic hit;
        logic same;
        int   k;
        hit = 1'b0;
        for (int off = 0; off < bpb_pkg::WINDOW_BYTES; off++)
        begin
            same = ((off + int'(plen)) <= int'(wlen));
            for (int j = 0; j < bpb_pkg::MAX_PATTERN_BYTES; j++)
            begin
                k = off + j;
                if ((j < int'(plen)) && (k < bpb_pkg::WINDOW_BYTES))
                begin
                    if (win[k] != pat[j])
                    begin
                        same = 1'b0;
                    end
                end
            end
            hit = hit | same;
        end
        return hit && (plen != '0);
    endfunction

    always_comb
    begin
        for (int k = 0; k < bpb_pkg::MAX_PATTERN_BYTES; k++)
        begin
            if (k < 8)
            begin
                pat_bytes[k] = pat_low_reg[8*k +: 8];
            end
            else
            begin
                pat_bytes[k] = pat_high_reg[8*(k-8) +: 8];
            end
        end
        for (int k = 0; k < bpb_pkg::WINDOW_BYTES; k++)
        begin
            if (k < 8)
            begin
                orig_win[k] = req.old_low[8*k +: 8];
                repl_win[k] = req.new_low[8*k +: 8];
            end
            else
            begin
                orig_win[k] = req.old_high[8*(k-8) +: 8];
                repl_win[k] = req.new_high[8*(k-8) +: 8];
            end
        end
    end

    assign old_len_c = clamp_len(req.old_len, bpb_pkg::WINDOW_BYTES);
    assign new_len_c = clamp_len(req.new_len, bpb_pkg::WINDOW_BYTES);
    assign old_hit   = holds(orig_win, old_len_c, pat_bytes, len_reg);
    assign new_hit   = holds(repl_win, new_len_c, pat_bytes, len_reg);

    always_comb
    begin
        res_next.broken = (req.command == bpb_pkg::CMD_EVAL) && old_hit && !new_hit;
        res_next.weight = res_next.broken ? weight_reg : '0;
    end

    // pattern bytes are only read while the length is nonzero
    always_ff @(posedge clk)
    begin
        if (ctrl.write)
        begin
            pat_low_reg  <= req.pattern_low;
            pat_high_reg <= req.pattern_high;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            weight_reg <= '0;
            res_reg    <= '0;
        end
        else
        begin
            if (ctrl.write)
            begin
                len_reg    <= clamp_len(req.pattern_len, bpb_pkg::MAX_PATTERN_BYTES);
                weight_reg <= req.weight;
            end
            if (ctrl.match)
            begin
                res_reg <= res_next;
            end
        end
    end

    assign res = res_reg;

endmodule

[rtl/bpb_merge.sv]
module bpb_merge
(
    input  logic               clk,
    input  bpb_pkg::lane_res_t lanes [bpb_pkg::PATTERN_SLOTS],
    output bpb_pkg::lane_res_t top
);

    // heap order: node n has children 2n and 2n+1, leaves above MERGE_NODES-1
    bpb_pkg::lane_res_t tree_reg [1:bpb_pkg::MERGE_NODES-1];
    bpb_pkg::lane_res_t leaf     [bpb_pkg::MERGE_NODES];

    function automatic bpb_pkg::lane_res_t combine(
        input bpb_pkg::lane_res_t a,
        input bpb_pkg::lane_res_t b
    );
        bpb_pkg::lane_res_t r;
        r.broken = a.broken | b.broken;
        r.weight = (a.weight > b.weight) ? a.weight : b.weight;
        return r;
    endfunction

    always_comb
    begin
        for (int i = 0; i < bpb_pkg::MERGE_NODES; i++)
        begin
            if (i < bpb_pkg::PATTERN_SLOTS)
            begin
                leaf[i] = lanes[i];
            end
            else
            begin
                leaf[i] = '0;
            end
        end
    end

    // one tree level settles per clock
    always_ff @(posedge clk)
    begin
        for (int n = 1; n < bpb_pkg::MERGE_NODES; n++)
        begin
            if (2*n >= bpb_pkg::MERGE_NODES)
            begin
                tree_reg[n] <= combine(leaf[2*n - bpb_pkg::MERGE_NODES],
                                       leaf[2*n + 1 - bpb_pkg::MERGE_NODES]);
            end
            else
            begin
                tree_reg[n] <= combine(tree_reg[2*n], tree_reg[2*n + 1]);
            end
        end
    end

    assign top = tree_reg[1];

endmodule

[rtl/bpb_check.sv]
module bpb_check
(
    input logic             clk,
    input logic             rst_n,
    input logic             request_valid,
    input logic             request_stall,
    input logic             result_valid,
    input logic             result_stall,
    input bpb_pkg::result_t result
);

    // a waiting result is not withdrawn
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // a nonzero boost only comes from a broken pattern
    a_boost_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.boost != '0) |-> result.any_broken)
        else $error("boost without any_broken");

    // one request at a time: an accepted request closes the input
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && !request_stall |=> request_stall)
        else $error("request taken while busy");

    // a fresh result only follows work in flight
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(request_stall))
        else $error("result without a request in flight");

endmodule

bind broken_pattern_boost bpb_check u_bpb_check
(
    .clk           (clk),
    .rst_n         (rst_n),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
);
